// ===== hw/rtl/rv32iexe_pkg.sv =====
`default_nettype none
package rv32iexe_pkg;

    localparam int XLEN      = 32;
    localparam int REG_W     = 5;
    localparam int OP_W      = 4;
    localparam int IMM_W     = 12;
    localparam int FILL_AW   = 12;
    localparam int BYTE_W    = 8;
    localparam int NUM_LANES = 4;
    localparam int LANE_W    = 2;

    localparam logic [XLEN-1:0] PC_STEP = 32'd4;

    typedef enum logic [OP_W-1:0] {
        OP_LB    = 4'd0,
        OP_LH    = 4'd1,
        OP_LW    = 4'd2,
        OP_LBU   = 4'd3,
        OP_LHU   = 4'd4,
        OP_ADDI  = 4'd5,
        OP_XORI  = 4'd6,
        OP_ANDI  = 4'd7,
        OP_ORI   = 4'd8,
        OP_SLTI  = 4'd9,
        OP_SLTIU = 4'd10,
        OP_SLLI  = 4'd11,
        OP_SRLI  = 4'd12,
        OP_SRAI  = 4'd13,
        OP_JALR  = 4'd14,
        OP_FILL  = 4'd15
    } t_op;

    typedef logic [XLEN-1:0]   t_word;
    typedef logic [REG_W-1:0]  t_reg_idx;
    typedef logic [BYTE_W-1:0] t_byte;

endpackage
`default_nettype wire

// ===== hw/rtl/rv32iexe_insn_if.sv =====
`default_nettype none
interface rv32iexe_insn_if;
    import rv32iexe_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         opcode;
    logic [REG_W-1:0]        dest_index;
    logic [REG_W-1:0]        source_index;
    logic signed [IMM_W-1:0] immediate;
    logic [FILL_AW-1:0]      fill_address;
    logic [BYTE_W-1:0]       fill_data;

    modport source (
        output valid, opcode, dest_index, source_index, immediate, fill_address, fill_data,
        input  ready
    );

    modport sink (
        input  valid, opcode, dest_index, source_index, immediate, fill_address, fill_data,
        output ready
    );
endinterface
`default_nettype wire

// ===== hw/rtl/rv32iexe_res_if.sv =====
`default_nettype none
interface rv32iexe_res_if;
    import rv32iexe_pkg::*;

    logic             valid;
    logic             ready;
    logic             reg_written;
    logic [REG_W-1:0] written_index;
    logic [XLEN-1:0]  written_value;
    logic [XLEN-1:0]  new_pc;

    modport source (
        output valid, reg_written, written_index, written_value, new_pc,
        input  ready
    );

    modport sink (
        input  valid, reg_written, written_index, written_value, new_pc,
        output ready
    );
endinterface
`default_nettype wire

// ===== hw/rtl/rv32i_itype_execute_top.sv =====
`default_nettype none
// Executes one RV32I I-type instruction per item against a 32-entry register file, a program
// counter and a byte-wide data memory of MEM_BYTES bytes, which must be a power of two. In the
// input stage the source register of an item is read (forwarded from the item ahead of it if
// that one writes it), the ALU result, the effective address and the next PC are formed, and
// the memory lanes are addressed; its result is registered into the output stage, and one item
// is accepted every cycle while the output is being taken. The memory is split into four byte
// lanes of MEM_BYTES/4 rows, each with one write and one read port, so a misaligned halfword or
// word load reads all its bytes in a single access. After reset the block runs a clearing pass
// over the MEM_BYTES/4 rows of the memory and accepts no item until it has finished.
module rv32i_itype_execute_top #(
    parameter int MEM_BYTES = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    rv32iexe_insn_if.sink    i_insn,
    rv32iexe_res_if.source   o_result
);
    import rv32iexe_pkg::*;

    localparam int ADDR_W = $clog2(MEM_BYTES);
    localparam int ROWS   = MEM_BYTES / NUM_LANES;
    localparam int ROW_W  = $clog2(ROWS);

    // Clearing pass.
    logic             r_clr_busy;
    logic [ROW_W-1:0] r_clr_row;

    // Input stage.
    logic                    r_a_valid;
    t_op                     r_a_op;
    t_reg_idx                r_a_rd;
    t_reg_idx                r_a_rs1;
    logic signed [IMM_W-1:0] r_a_imm;
    logic [FILL_AW-1:0]      r_a_fill_addr;
    t_byte                   r_a_fill_data;

    // Output stage.
    logic              r_b_valid;
    t_op               r_b_op;
    t_reg_idx          r_b_rd;
    logic              r_b_wr;
    t_word             r_b_alu;
    logic [LANE_W-1:0] r_b_off;
    t_word             r_b_pc;

    t_word r_pc;
    t_word r_rf [32];

    logic  a_adv;
    logic  in_fire;
    logic  out_fire;
    t_word b_val;
    t_word src;
    t_word imm32;
    t_word ea;
    t_word alu;
    t_word n_pc;
    logic [4:0] sh;
    logic  fill_go;
    logic [ADDR_W-1:0] fill_a;
    logic [ADDR_W-1:0] ea_a;
    logic [ROW_W-1:0]  row0;
    logic [ROW_W-1:0]  row1;

    t_byte            lane_rd_data [NUM_LANES];
    logic [ROW_W-1:0] lane_rd_addr [NUM_LANES];
    logic             lane_wr_en   [NUM_LANES];
    logic [ROW_W-1:0] lane_wr_addr;
    t_byte            lane_wr_data;

    t_byte by0, by1, by2, by3;

    assign out_fire = r_b_valid && o_result.ready;
    assign a_adv    = r_a_valid && (!r_b_valid || o_result.ready);
    assign i_insn.ready = !r_clr_busy && (!r_a_valid || a_adv);
    assign in_fire  = i_insn.valid && i_insn.ready;

    // Output stage value, including load formatting.
    assign by0 = lane_rd_data[r_b_off];
    assign by1 = lane_rd_data[r_b_off + 2'd1];
    assign by2 = lane_rd_data[r_b_off + 2'd2];
    assign by3 = lane_rd_data[r_b_off + 2'd3];

    always_comb begin
        case (r_b_op)
            OP_LB:   b_val = {{24{by0[7]}}, by0};
            OP_LH:   b_val = {{16{by1[7]}}, by1, by0};
            OP_LW:   b_val = {by3, by2, by1, by0};
            OP_LBU:  b_val = {24'd0, by0};
            OP_LHU:  b_val = {16'd0, by1, by0};
            default: b_val = r_b_alu;
        endcase
    end

    assign o_result.valid         = r_b_valid;
    assign o_result.reg_written   = r_b_wr;
    assign o_result.written_index = r_b_wr ? r_b_rd : '0;
    assign o_result.written_value = r_b_wr ? b_val : '0;
    assign o_result.new_pc        = r_b_pc;

    // Input stage: source read with forwarding, ALU and address generation.
    always_comb begin
        if (r_a_rs1 == '0) begin
            src = '0;
        end else if (r_b_valid && r_b_wr && (r_b_rd == r_a_rs1)) begin
            src = b_val;
        end else begin
            src = r_rf[r_a_rs1];
        end
    end

    assign imm32 = t_word'(r_a_imm);
    assign sh    = r_a_imm[4:0];
    assign ea    = src + imm32;

    always_comb begin
        n_pc = r_pc + PC_STEP;
        case (r_a_op)
            OP_ADDI:  alu = ea;
            OP_XORI:  alu = src ^ imm32;
            OP_ANDI:  alu = src & imm32;
            OP_ORI:   alu = src | imm32;
            OP_SLTI:  alu = {31'd0, $signed(src) < $signed(imm32)};
            OP_SLTIU: alu = {31'd0, src < imm32};
            OP_SLLI:  alu = src << sh;
            OP_SRLI:  alu = src >> sh;
            OP_SRAI:  alu = t_word'($signed(src) >>> sh);
            OP_JALR: begin
                alu  = r_pc + PC_STEP;
                n_pc = {ea[XLEN-1:1], 1'b0};
            end
            default:  alu = '0;
        endcase
    end

    // Memory lane addressing.
    assign fill_go = a_adv && (r_a_op == OP_FILL);
    assign fill_a  = ADDR_W'(t_word'(r_a_fill_addr));
    assign ea_a    = ea[ADDR_W-1:0];
    assign row0    = ea_a[ADDR_W-1:LANE_W];
    assign row1    = row0 + ROW_W'(1);

    assign lane_wr_addr = r_clr_busy ? r_clr_row : fill_a[ADDR_W-1:LANE_W];
    assign lane_wr_data = r_clr_busy ? '0 : r_a_fill_data;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        assign lane_wr_en[g] = r_clr_busy
                            || (fill_go && (fill_a[LANE_W-1:0] == LANE_W'(g)));
        assign lane_rd_addr[g] = (LANE_W'(g) >= ea_a[LANE_W-1:0]) ? row0 : row1;

        rv32iexe_ram #(
            .WIDTH (BYTE_W),
            .DEPTH (ROWS)
        ) u_lane (
            .i_clk     (i_clk),
            .i_wr_en   (lane_wr_en[g]),
            .i_wr_addr (lane_wr_addr),
            .i_wr_data (lane_wr_data),
            .i_rd_en   (a_adv),
            .i_rd_addr (lane_rd_addr[g]),
            .o_rd_data (lane_rd_data[g])
        );
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
            r_a_valid  <= 1'b0;
            r_b_valid  <= 1'b0;
            r_pc       <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_row <= r_clr_row + ROW_W'(1);
                if (r_clr_row == ROW_W'(ROWS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (in_fire) begin
                r_a_valid <= 1'b1;
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (a_adv) begin
                r_b_valid <= 1'b1;
                r_pc      <= n_pc;
            end else if (out_fire) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    // Register file, written as each result is delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 32; i++) begin
                r_rf[i] <= '0;
            end
        end else if (out_fire && r_b_wr) begin
            r_rf[r_b_rd] <= b_val;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a_op        <= t_op'(i_insn.opcode);
            r_a_rd        <= i_insn.dest_index;
            r_a_rs1       <= i_insn.source_index;
            r_a_imm       <= i_insn.immediate;
            r_a_fill_addr <= i_insn.fill_address;
            r_a_fill_data <= i_insn.fill_data;
        end
        if (a_adv) begin
            r_b_op  <= r_a_op;
            r_b_rd  <= r_a_rd;
            r_b_wr  <= (r_a_op != OP_FILL) && (r_a_rd != '0);
            r_b_alu <= alu;
            r_b_off <= ea_a[LANE_W-1:0];
            r_b_pc  <= n_pc;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/rv32iexe_ram.sv =====
`default_nettype none
module rv32iexe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire
